// ===== src/fifo_ready_queue_with_removal_assert.svh =====
// Assertion macros for the ready queue.
// Used at the end of the top level; needs nothing else.
`ifndef FIFO_READY_QUEUE_WITH_REMOVAL_ASSERT_SVH
`define FIFO_READY_QUEUE_WITH_REMOVAL_ASSERT_SVH

// Same-cycle check, off while reset is low.
`define FRQR_ASSERT_NOW(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("frqr check failed");

// Cause in this cycle, effect in the next.
`define FRQR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("frqr check failed");

`endif

// ===== src/frqr_pkg.sv =====
// Shared types and codes for the ready queue.
// No dependencies.
package frqr_pkg;

    localparam int KIND_W   = 2;
    localparam int TID_W    = 16;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 6;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADMIT  = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_CLEAR  = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // Per-beat command broadcast to every cell.
    typedef struct packed {
        logic admit;
        logic remove;
    } t_cell_ctrl;

endpackage

// ===== src/frqr_cell.sv =====
// One slot of the ready queue chain: holds one id, matches it, shifts up on remove.
// Depends on frqr_pkg.
module frqr_cell
    import frqr_pkg::*;
#(
    parameter int IDX     = 0,
    parameter int ID_BITS = 16,
    parameter int CNT_W   = 6
) (
    input  logic               i_clk,
    input  t_cell_ctrl         i_ctrl,
    input  logic [ID_BITS-1:0] i_id,
    input  logic [CNT_W-1:0]   i_count,
    input  logic               i_hit,
    input  logic [ID_BITS-1:0] i_nbr_id,
    output logic               o_hit,
    output logic [ID_BITS-1:0] o_id,
    output logic [ID_BITS-1:0] o_next_id
);

    logic [ID_BITS-1:0] r_id;
    logic [ID_BITS-1:0] n_id;
    logic               w_occupied;
    logic               w_match;

    assign w_occupied = i_count > CNT_W'(IDX);
    assign w_match    = w_occupied && (r_id == i_id);
    // Hit ripples toward the tail: every slot at or after the first match shifts.
    assign o_hit      = i_hit | w_match;

    always_comb begin
        n_id = r_id;
        if (i_ctrl.admit && (i_count == CNT_W'(IDX))) begin
            n_id = i_id;
        end else if (i_ctrl.remove && o_hit) begin
            n_id = i_nbr_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
    end

    assign o_id      = r_id;
    assign o_next_id = n_id;

endmodule

// ===== src/fifo_ready_queue_with_removal.sv =====
// Top level of the ready queue: command decode, entry count, cell chain, result register.
// Depends on frqr_pkg, frqr_cell and fifo_ready_queue_with_removal_assert.svh.
//
// Ready queue of thread ids kept in arrival order in a row of cells.
// Input beats on s_axis: tuser carries the operation (admit at tail, remove
// first match, clear), tdata carries the thread id. Every input beat yields
// exactly one result beat on m_axis with status, head valid flag, head id
// and queue length after the operation.
// The result is registered and appears in the cycle after the input beat is accepted.
// Throughput: one beat per cycle while the receiver takes each result. Match and
// compaction are combinational; the match chain ripples through all QUEUE_DEPTH
// cells, which sets the critical path.
// A full queue drops an admit (status full); a remove on an empty queue or
// of an absent id leaves the queue alone and reports it.
// Reset empties the queue and drops any pending result; slot contents are
// not cleared, only the count.
// When the receiver stalls the result register holds and s_axis_tready
// falls until the result is taken.
module fifo_ready_queue_with_removal
    import frqr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32,
    parameter int ID_BITS     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [15:0] thread_id
    input  logic [1:0]  s_axis_tuser,  // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // [1:0] status, [2] head_valid,
                                       // [18:3] head_thread, [24:19] queue_length,
                                       // [31:25] zero
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    t_status            r_status;
    t_status            n_status;
    logic               r_head_valid;
    logic [TID_W-1:0]   r_head;
    logic [LEN_W-1:0]   r_len;

    logic               w_accept;
    logic               w_full;
    logic               w_found;
    t_kind              w_kind;
    t_cell_ctrl         w_ctrl;
    logic [ID_BITS-1:0] w_in_id;

    logic               w_hit  [0:QUEUE_DEPTH];
    logic [ID_BITS-1:0] w_id   [0:QUEUE_DEPTH-1];
    logic [ID_BITS-1:0] w_nid  [0:QUEUE_DEPTH-1];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_kind        = t_kind'(s_axis_tuser);
    assign w_in_id       = ID_BITS'(s_axis_tdata);
    assign w_full        = r_count == CNT_W'(QUEUE_DEPTH);
    assign w_hit[0]      = 1'b0;
    assign w_found       = w_hit[QUEUE_DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            frqr_cell #(
                .IDX     (gi),
                .ID_BITS (ID_BITS),
                .CNT_W   (CNT_W)
            ) u_cell (
                .i_clk     (i_clk),
                .i_ctrl    (w_ctrl),
                .i_id      (w_in_id),
                .i_count   (r_count),
                .i_hit     (w_hit[gi]),
                .i_nbr_id  (w_id[(gi + 1 < QUEUE_DEPTH) ? gi + 1 : gi]),
                .o_hit     (w_hit[gi + 1]),
                .o_id      (w_id[gi]),
                .o_next_id (w_nid[gi])
            );
        end
    endgenerate

    always_comb begin
        w_ctrl   = '0;
        n_count  = r_count;
        n_status = ST_OK;
        if (w_accept) begin
            case (w_kind)
                KIND_ADMIT: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctrl.admit = 1'b1;
                        n_count      = r_count + CNT_W'(1);
                    end
                end
                KIND_REMOVE: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else if (!w_found) begin
                        n_status = ST_NOT_FOUND;
                    end else begin
                        w_ctrl.remove = 1'b1;
                        n_count       = r_count - CNT_W'(1);
                    end
                end
                KIND_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    // unused code: ignore the beat, report ok
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status     <= n_status;
            r_head_valid <= n_count != '0;
            r_head       <= (n_count != '0) ? TID_W'(w_nid[0]) : '0;
            r_len        <= LEN_W'(n_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_len, r_head, r_head_valid, r_status};

`include "fifo_ready_queue_with_removal_assert.svh"

    `FRQR_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(QUEUE_DEPTH))
    `FRQR_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n,
        w_accept && (w_kind == KIND_CLEAR), (r_count == '0) && (r_len == '0))
    `FRQR_ASSERT_NEXT(a_admit_grows, i_clk, i_rst_n,
        w_accept && (w_kind == KIND_ADMIT) && !w_full,
        (r_count == $past(r_count) + CNT_W'(1)) && (r_status == ST_OK))
    `FRQR_ASSERT_NOW(a_head_flag, i_clk, i_rst_n,
        !r_out_valid || (r_head_valid == (r_len != '0)) || (CNT_W > LEN_W))

endmodule

// ===== tb/sv/tb_fifo_ready_queue_with_removal.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the thread ready queue: admits, first-match removes, clears.
// Depends on frqr_pkg and the fifo_ready_queue_with_removal top level.
module tb_fifo_ready_queue_with_removal;
    import frqr_pkg::*;

    localparam int          DEPTH          = 32;
    localparam int          RANDOM_ITEMS   = 900;
    localparam int          STALL_LIMIT    = 2000;
    localparam int          DRAIN_CYCLES   = 5;
    localparam logic [1:0]  KIND_RESERVED  = 2'd3;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;  // [15:0] thread_id
    logic [1:0]  s_axis_tuser  = '0;  // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [1:0] status, [2] head_valid, [18:3] head_thread,
                                      // [24:19] queue_length, [31:25] zero
    logic        no_idle = 1'b0;

    fifo_ready_queue_with_removal #(
        .QUEUE_DEPTH(DEPTH),
        .ID_BITS    (TID_W)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    typedef struct {
        t_status          status;
        logic             head_valid;
        logic [TID_W-1:0] head_thread;
        logic [LEN_W-1:0] queue_length;
    } t_queue_report;

    class ready_queue_scoreboard;
        logic [TID_W-1:0] ready_ids[$];
        t_queue_report    reports[$];
        int               errors;
        int               kind_seen[4];
        int               status_seen[4];
        int               checked;

        function new();
            errors  = 0;
            checked = 0;
            foreach (kind_seen[k]) kind_seen[k] = 0;
            foreach (status_seen[k]) status_seen[k] = 0;
        endfunction

        // Apply one accepted command to the mirror and queue the report it yields.
        function void note_command(logic [1:0] kind, logic [TID_W-1:0] tid);
            t_queue_report rep;
            int            hit;
            rep.status = ST_OK;
            hit = -1;
            case (kind)
                KIND_ADMIT: begin
                    if (ready_ids.size() >= DEPTH) rep.status = ST_FULL;
                    else ready_ids.push_back(tid);
                end
                KIND_REMOVE: begin
                    if (ready_ids.size() == 0) begin
                        rep.status = ST_EMPTY;
                    end else begin
                        for (int i = 0; i < ready_ids.size() && hit < 0; i++)
                            if (ready_ids[i] == tid) hit = i;
                        if (hit < 0) rep.status = ST_NOT_FOUND;
                        else ready_ids.delete(hit);
                    end
                end
                KIND_CLEAR: ready_ids.delete();
                default: ;
            endcase
            rep.head_valid   = (ready_ids.size() > 0);
            rep.head_thread  = (ready_ids.size() > 0) ? ready_ids[0] : '0;
            rep.queue_length = LEN_W'(ready_ids.size());
            reports.push_back(rep);
            kind_seen[kind]++;
            status_seen[rep.status]++;
        endfunction

        function void check_beat(logic [31:0] beat);
            t_queue_report rep;
            if (reports.size() == 0) begin
                $error("result beat 0x%08h with no command pending", beat);
                errors++;
                return;
            end
            rep = reports.pop_front();
            checked++;
            if (beat[1:0] !== rep.status) begin
                $error("status: expected %0d, actual %0d", rep.status, beat[1:0]);
                errors++;
            end
            if (beat[2] !== rep.head_valid) begin
                $error("head_valid: expected %0d, actual %0d", rep.head_valid, beat[2]);
                errors++;
            end
            if (beat[18:3] !== rep.head_thread) begin
                $error("head_thread: expected 0x%04h, actual 0x%04h",
                       rep.head_thread, beat[18:3]);
                errors++;
            end
            if (beat[24:19] !== rep.queue_length) begin
                $error("queue_length: expected %0d, actual %0d",
                       rep.queue_length, beat[24:19]);
                errors++;
            end
            if (beat[31:25] !== 7'd0) begin
                $error("padding: expected 0x00, actual 0x%02h", beat[31:25]);
                errors++;
            end
        endfunction

        function int pending();
            return reports.size();
        endfunction
    endclass

    ready_queue_scoreboard sb = new();

    logic [TID_W-1:0] id_pool[8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                     16'hAAAA, 16'h5555, 16'h00FF, 16'hFF00};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= 33);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready) sb.note_command(s_axis_tuser, s_axis_tdata);
        end
    end

    // Abort when no beat moves on either side for too long.
    int stall_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d idle cycles, %0d results pending",
                     stall_cycles, sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_command(logic [1:0] kind, logic [TID_W-1:0] tid);
        while (!no_idle && $urandom_range(99) < 33) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= tid;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic logic [TID_W-1:0] pick_tid();
        if ($urandom_range(99) < 70) return id_pool[$urandom_range(7)];
        return TID_W'($urandom_range(16'hFFFF));
    endfunction

    function automatic logic [1:0] pick_kind(int admit_pct);
        int r;
        r = $urandom_range(99);
        if (r < 2) return KIND_CLEAR;
        if (r == 2) return KIND_RESERVED;
        if (r < admit_pct + 3) return KIND_ADMIT;
        return KIND_REMOVE;
    endfunction

    initial begin
        int          n_random;
        int          admit_pct;
        logic [1:0]  kind;
        int          phase_pct[5];

        phase_pct = '{95, 50, 70, 30, 60};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-queue cases, id extremes, duplicates, middle remove, reserved kind.
        send_command(KIND_REMOVE, 16'h1234);
        send_command(KIND_CLEAR, 16'hFFFF);
        send_command(KIND_ADMIT, 16'h0000);
        send_command(KIND_ADMIT, 16'hFFFF);
        send_command(KIND_ADMIT, 16'hFFFF);
        send_command(KIND_ADMIT, 16'hA5A5);
        send_command(KIND_REMOVE, 16'h1234);
        send_command(KIND_REMOVE, 16'hFFFF);
        send_command(KIND_RESERVED, 16'h5A5A);
        send_command(KIND_REMOVE, 16'h0000);
        send_command(KIND_REMOVE, 16'hA5A5);
        send_command(KIND_REMOVE, 16'hFFFF);
        send_command(KIND_REMOVE, 16'hFFFF);
        send_command(KIND_ADMIT, 16'h8001);
        send_command(KIND_CLEAR, 16'h0000);
        send_command(KIND_ADMIT, 16'h7FFE);

        // Random: phases of varying admit bias, the first one heavy enough to fill the queue.
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            admit_pct = phase_pct[(n_random / 60) % 5];
            no_idle   = (n_random >= 400 && n_random < 550);
            kind      = pick_kind(admit_pct);
            send_command(kind, pick_tid());
            if (kind != KIND_RESERVED) n_random++;
        end
        s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;

        // Let the monitor note the last accepted beat before draining.
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("commands: %0d admit, %0d remove, %0d clear, %0d reserved; %0d results checked",
                 sb.kind_seen[KIND_ADMIT], sb.kind_seen[KIND_REMOVE],
                 sb.kind_seen[KIND_CLEAR], sb.kind_seen[KIND_RESERVED], sb.checked);
        $display("status mix: %0d ok, %0d empty, %0d not found, %0d full",
                 sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY],
                 sb.status_seen[ST_NOT_FOUND], sb.status_seen[ST_FULL]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
